FILE: rtl/dae_pkg.sv
`timescale 1ns / 1ps

package dae_pkg;

   // q16 fixed point
   localparam int unsigned Q16_W = 17;
   localparam logic [16:0] Q16_ONE = 17'd65536;
   localparam logic [17:0] Q17_TWO = 18'd131072;

   // counter and sequence widths
   localparam int unsigned CNT_W = 32;
   localparam int unsigned SEQ_W = 32;
   localparam int unsigned SEG_W = 16;

   // shared multiplier operand and product widths
   localparam int unsigned MUL_A_W = 32;
   localparam int unsigned MUL_B_W = 18;
   localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

   // fraction bits produced by the divider
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned DIV_CNT_W = $clog2(FRAC_W);

   // configuration register file
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_INIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_SIZE = 2'd2;

   // reset values
   localparam logic [16:0] GAIN_RESET = 17'd4096;
   localparam logic [16:0] ALPHA_RESET = 17'd65536;
   localparam logic [15:0] SEG_SIZE_RESET = 16'd536;

   // input word
   typedef struct packed {
      logic             mode;
      logic [SEG_W-1:0] segments_acked;
      logic             ece_seen;
      logic [SEQ_W-1:0] acked_seq;
      logic [SEQ_W-1:0] next_tx_seq;
      logic [CNT_W-1:0] cwnd_bytes;
   } req_type;

   // result word
   typedef struct packed {
      logic [Q16_W-1:0] alpha_q16;
      logic [CNT_W-1:0] ssthresh_bytes;
      logic             window_done;
      logic [CNT_W-1:0] marked_bytes_out;
      logic [CNT_W-1:0] total_bytes_out;
   } rsp_type;

   // item modes
   localparam logic MODE_ACK = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // divider control and status
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] marked;
      logic [CNT_W-1:0] total;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [Q16_W-1:0] quot;
   } div_sts_type;

endpackage

FILE: rtl/dae_div.sv
`timescale 1ns / 1ps

// marked / total in q16, clamped to one, zero for an empty window
module dae_div import dae_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_sts_type div_sts
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     dvsr_ff, dvsr_in;
   logic [Q16_W-1:0]     quot_ff, quot_in;

   logic [CNT_W:0] shifted;
   logic           ge;
   logic [CNT_W:0] diff;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      ge      = shifted >= {1'b0, dvsr_ff};
      diff    = shifted - {1'b0, dvsr_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      quot_in = quot_ff;

      if (div_req.start) begin
         dvsr_in = div_req.total;
         rem_in  = div_req.marked;
         cnt_in  = DIV_CNT_W'(FRAC_W - 1);
         if (div_req.total == '0) begin
            quot_in = '0;
            done_in = 1'b1;
         end else if (div_req.marked >= div_req.total) begin
            quot_in = Q16_ONE;
            done_in = 1'b1;
         end else begin
            quot_in = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // one restoring step per cycle
         rem_in  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quot_in = {quot_ff[Q16_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      quot_ff <= quot_in;
   end

   assign div_sts.done = done_ff;
   assign div_sts.quot = quot_ff;

endmodule

FILE: rtl/dctcp_alpha_estimator.sv
`timescale 1ns / 1ps

// channel | direction | handshake             | word
// req     | in        | req_valid / req_stall | req_type: ack or ssthresh query
// rsp     | out       | rsp_valid / rsp_stall | rsp_type: alpha, ssthresh, window counters
// csr     | in        | csr_we                | csr_index, csr_wdata, no read-back
//
// one word at a time through a shared 32x18 multiplier and a bit-serial divider
// ack that keeps the window open: segment multiply, accumulate, output; query: multiply, scale, output
// ack that closes the window: adds the 16-step fraction divide and the ewma steps
// closing ack with an empty or fully marked window skips the divide steps
// req_stall is high from acceptance until the result is loaded into the rsp register
// the rsp register holds a stalled word, a new word may be accepted meanwhile
module dctcp_alpha_estimator import dae_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // sequencer states
   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_SEG  = 10'b0000000010,  // segments times segment size
      ST_ACC  = 10'b0000000100,  // accumulate, window compare
      ST_DIV  = 10'b0000001000,  // wait for the marked fraction
      ST_EW1  = 10'b0000010000,  // (1-g) * alpha
      ST_EW2  = 10'b0000100000,  // g * m
      ST_EW3  = 10'b0001000000,  // sum and shift into alpha
      ST_QRY  = 10'b0010000000,  // cwnd * (2 - alpha)
      ST_QFIN = 10'b0100000000,  // scale query product
      ST_OUT  = 10'b1000000000   // hand the word to the rsp register
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [Q16_W-1:0] gain_ff, gain_in;
   logic [SEG_W-1:0] seg_size_ff, seg_size_in;
   logic [Q16_W-1:0] csr_q16;

   // estimator state
   logic [Q16_W-1:0] alpha_ff, alpha_in;
   logic [CNT_W-1:0] marked_ff, marked_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [SEQ_W-1:0] win_end_ff, win_end_in;
   logic             armed_ff, armed_in;

   // captured request and working registers
   req_type          req_ff, req_in;
   logic [MUL_P_W-1:0] prod_ff;
   logic [CNT_W:0]   acc_ff, acc_in;
   logic [Q16_W-1:0] m_ff, m_in;

   // staged result fields
   logic [CNT_W-1:0] res_ssth_ff, res_ssth_in;
   logic             res_done_ff, res_done_in;
   logic [CNT_W-1:0] res_marked_ff, res_marked_in;
   logic [CNT_W-1:0] res_total_ff, res_total_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rsp_load;

   // shared multiplier
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;

   // accumulate helpers
   logic [CNT_W-1:0] add_bytes;
   logic [CNT_W:0]   tot_sum, mrk_sum;
   logic [CNT_W-1:0] tot_sat, mrk_sat;
   logic [SEQ_W-1:0] cur_end, seq_diff;
   logic             win_close;
   logic [CNT_W:0]   ewma_sum;
   logic [CNT_W:0]   alpha_wide;

   div_req_type div_req;
   div_sts_type div_sts;

   dae_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   // gain and alpha writes saturate at one
   assign csr_q16 = (csr_wdata > Q16_ONE) ? Q16_ONE : csr_wdata;

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SEG: begin
            mul_a = MUL_A_W'(req_ff.segments_acked);
            mul_b = MUL_B_W'(seg_size_ff);
         end
         ST_QRY: begin
            mul_a = req_ff.cwnd_bytes;
            mul_b = Q17_TWO - MUL_B_W'(alpha_ff);
         end
         ST_EW1: begin
            mul_a = MUL_A_W'(Q16_ONE - gain_ff);
            mul_b = MUL_B_W'(alpha_ff);
         end
         ST_EW2: begin
            mul_a = MUL_A_W'(gain_ff);
            mul_b = MUL_B_W'(m_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // saturating accumulate and wrap-aware window compare
   always_comb begin
      add_bytes = prod_ff[CNT_W-1:0];
      tot_sum   = {1'b0, total_ff} + {1'b0, add_bytes};
      mrk_sum   = {1'b0, marked_ff} + {1'b0, add_bytes};
      tot_sat   = tot_sum[CNT_W] ? '1 : tot_sum[CNT_W-1:0];
      mrk_sat   = req_ff.ece_seen ? (mrk_sum[CNT_W] ? '1 : mrk_sum[CNT_W-1:0]) : marked_ff;
      cur_end   = armed_ff ? win_end_ff : req_ff.next_tx_seq;
      seq_diff  = req_ff.acked_seq - cur_end;
      win_close = !seq_diff[SEQ_W-1];
      // the two ewma terms share the weight 65536, so the sum stays within 33 bits
      ewma_sum   = acc_ff + prod_ff[CNT_W:0];
      alpha_wide = ewma_sum >> FRAC_W;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      gain_in       = gain_ff;
      seg_size_in   = seg_size_ff;
      alpha_in      = alpha_ff;
      marked_in     = marked_ff;
      total_in      = total_ff;
      win_end_in    = win_end_ff;
      armed_in      = armed_ff;
      req_in        = req_ff;
      acc_in        = acc_ff;
      m_in          = m_ff;
      res_ssth_in   = res_ssth_ff;
      res_done_in   = res_done_ff;
      res_marked_in = res_marked_ff;
      res_total_in  = res_total_ff;
      div_req.start  = 1'b0;
      div_req.marked = mrk_sat;
      div_req.total  = tot_sat;

      // register writes, only while idle: the user must keep to this, the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            CSR_GAIN:       gain_in = csr_q16;
            CSR_ALPHA_INIT: alpha_in = csr_q16;
            CSR_SEG_SIZE:   seg_size_in = csr_wdata[SEG_W-1:0];
            default:        ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               res_ssth_in   = '0;
               res_done_in   = 1'b0;
               res_marked_in = '0;
               res_total_in  = '0;
               state_in      = (req_data.mode == MODE_QUERY) ? ST_QRY : ST_SEG;
            end
         end
         ST_SEG: state_in = ST_ACC;
         ST_ACC: begin
            armed_in = 1'b1;
            if (win_close) begin
               // hand the window to the divider, then start a fresh one
               div_req.start = 1'b1;
               res_done_in   = 1'b1;
               res_marked_in = mrk_sat;
               res_total_in  = tot_sat;
               marked_in     = '0;
               total_in      = '0;
               win_end_in    = req_ff.next_tx_seq;
               state_in      = ST_DIV;
            end else begin
               marked_in  = mrk_sat;
               total_in   = tot_sat;
               win_end_in = cur_end;
               state_in   = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               m_in     = div_sts.quot;
               state_in = ST_EW1;
            end
         end
         ST_EW1: state_in = ST_EW2;
         ST_EW2: begin
            acc_in   = prod_ff[CNT_W:0];
            state_in = ST_EW3;
         end
         ST_EW3: begin
            alpha_in = (alpha_wide > CNT_W'(Q16_ONE)) ? Q16_ONE : alpha_wide[Q16_W-1:0];
            state_in = ST_OUT;
         end
         ST_QRY:  state_in = ST_QFIN;
         ST_QFIN: begin
            res_ssth_in = prod_ff[CNT_W+Q16_W-1:Q16_W];
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register: a stalled word holds, a taken word clears valid
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.alpha_q16        = alpha_ff;
         rsp_data_in.ssthresh_bytes   = res_ssth_ff;
         rsp_data_in.window_done      = res_done_ff;
         rsp_data_in.marked_bytes_out = res_marked_ff;
         rsp_data_in.total_bytes_out  = res_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_RESET;
         seg_size_ff  <= SEG_SIZE_RESET;
         alpha_ff     <= ALPHA_RESET;
         marked_ff    <= '0;
         total_ff     <= '0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         seg_size_ff  <= seg_size_in;
         alpha_ff     <= alpha_in;
         marked_ff    <= marked_in;
         total_ff     <= total_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // window end is only read once armed
      win_end_ff    <= win_end_in;
      req_ff        <= req_in;
      prod_ff       <= mul_a * mul_b;
      acc_ff        <= acc_in;
      m_ff          <= m_in;
      res_ssth_ff   <= res_ssth_in;
      res_done_ff   <= res_done_in;
      res_marked_ff <= res_marked_in;
      res_total_ff  <= res_total_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
